/* sv/tles_pkg.sv */
// Shared types, constants and helpers for the trig linear equation solver.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package tles_pkg;

    // Fixed-point one in Q2.30
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Iteration counts of the shared sequential units
    localparam int SQRT_STEPS = 62;   // radicand below 2^124, one result bit a step
    localparam int DIV_STEPS  = 33;   // quotient is known to stay below 2^33
    localparam int CNT_W      = 6;

    // Result outcome codes
    localparam logic [1:0] OC_ROOT   = 2'd0;
    localparam logic [1:0] OC_NONE   = 2'd1;
    localparam logic [1:0] OC_SAMPLE = 2'd2;

    typedef struct packed {
        logic signed [31:0] coef_sin;
        logic signed [31:0] coef_cos;
        logic signed [31:0] coef_const;
    } tles_in_t;

    typedef struct packed {
        logic signed [31:0] root_cos;
        logic signed [31:0] root_sin;
        logic [1:0]         outcome;
        logic               last;
    } tles_out_t;

    // Classification made by the front
    typedef enum logic [1:0] {
        KIND_ROOTS,
        KIND_NONE,
        KIND_IDENT
    } tles_kind_t;

    // One classified item as it sits in the queue
    typedef struct packed {
        tles_kind_t  kind;
        logic        sa;
        logic        sb;
        logic        sc;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] s;
        logic [63:0] d;
        logic [63:0] ac;
        logic [63:0] bc;
    } tles_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT,
        ST_MUL,
        ST_ADD,
        ST_NUM,
        ST_DLOAD,
        ST_DIV,
        ST_ROUND,
        ST_EMIT
    } tles_state_t;

    // Magnitude of a 32-bit two's-complement value (the most negative value maps to 2^31)
    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

/* sv/tles_front.sv */
// Front of the solver: takes coefficient items, forms the exact squares and
// cross products and classifies each item. Depends on tles_pkg.
`timescale 1ns / 1ps

module tles_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tles_pkg::tles_in_t   in_data,
    output logic                 entry_valid,
    input  logic                 entry_ready,
    output tles_pkg::tles_entry_t entry
);
    import tles_pkg::*;

    logic        a_valid_reg, a_valid_next;
    logic        b_valid_reg, b_valid_next;
    logic [31:0] ma_a_reg, mb_a_reg, mc_a_reg;
    logic        sa_a_reg, sb_a_reg, sc_a_reg;
    logic [31:0] ma_b_reg, mb_b_reg;
    logic        sa_b_reg, sb_b_reg, sc_b_reg;
    logic [63:0] sq_a_reg, sq_b_reg, c2_reg, ac_reg, bc_reg;
    logic        a_move, b_free, in_take;
    logic [63:0] s_sum;

    // stage handshakes
    assign b_free   = !b_valid_reg || entry_ready;
    assign a_move   = a_valid_reg && b_free;
    assign in_ready = !a_valid_reg || a_move;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_take)
            a_valid_next = 1'b1;
        else if (a_move)
            a_valid_next = 1'b0;
        b_valid_next = b_valid_reg;
        if (a_move)
            b_valid_next = 1'b1;
        else if (entry_ready)
            b_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // stage A: signs and magnitudes
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ma_a_reg <= mag32(in_data.coef_sin);
            mb_a_reg <= mag32(in_data.coef_cos);
            mc_a_reg <= mag32(in_data.coef_const);
            sa_a_reg <= in_data.coef_sin[31];
            sb_a_reg <= in_data.coef_cos[31];
            sc_a_reg <= in_data.coef_const[31];
        end
    end

    // stage B: exact products
    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            sq_a_reg <= ma_a_reg * ma_a_reg;
            sq_b_reg <= mb_a_reg * mb_a_reg;
            c2_reg   <= mc_a_reg * mc_a_reg;
            ac_reg   <= ma_a_reg * mc_a_reg;
            bc_reg   <= mb_a_reg * mc_a_reg;
            ma_b_reg <= ma_a_reg;
            mb_b_reg <= mb_a_reg;
            sa_b_reg <= sa_a_reg;
            sb_b_reg <= sb_a_reg;
            sc_b_reg <= sc_a_reg;
        end
    end

    // classification on the way into the queue
    assign s_sum = sq_a_reg + sq_b_reg;

    always_comb
    begin
        entry.sa = sa_b_reg;
        entry.sb = sb_b_reg;
        entry.sc = sc_b_reg;
        entry.ma = ma_b_reg;
        entry.mb = mb_b_reg;
        entry.s  = s_sum;
        entry.d  = s_sum - c2_reg;
        entry.ac = ac_reg;
        entry.bc = bc_reg;
        if (ma_b_reg == 32'd0 && mb_b_reg == 32'd0)
            entry.kind = (c2_reg == 64'd0) ? KIND_IDENT : KIND_NONE;
        else if (c2_reg > s_sum)
            entry.kind = KIND_NONE;
        else
            entry.kind = KIND_ROOTS;
    end

    assign entry_valid = b_valid_reg;

endmodule

/* sv/tles_fifo.sv */
// Short queue of classified items between front and back.
// Depends on tles_pkg.
`timescale 1ns / 1ps

module tles_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  tles_pkg::tles_entry_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output tles_pkg::tles_entry_t pop_data
);
    import tles_pkg::*;

    tles_entry_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]         count_reg, count_next;
    logic                     push, pop;

    assign push_ready = (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

/* sv/tles_back.sv */
// Back of the solver: square root, numerators, two dividers and rounding,
// then result items through an output register. Depends on tles_pkg.
`timescale 1ns / 1ps

module tles_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  tles_pkg::tles_entry_t pop_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tles_pkg::tles_out_t   out_data
);
    import tles_pkg::*;

    tles_state_t  state_reg, state_next;
    tles_entry_t  ent_reg;
    logic         second_reg;
    logic [1:0]   idx_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [123:0] rem_reg, res_reg, bit_reg;
    logic [61:0]  q_reg;
    logic [62:0]  pa0_reg, pa1_reg, pb0_reg, pb1_reg;
    logic [93:0]  aq_reg, bq_reg;
    logic [95:0]  ncos_reg, nsin_reg;
    logic         negc_reg, negs_reg;
    logic [63:0]  drc_reg, drs_reg;
    logic [32:0]  dlc_reg, dls_reg, dqc_reg, dqs_reg;
    logic [31:0]  cos_f_reg, sin_f_reg;
    logic         out_valid_reg;
    tles_out_t    out_reg;

    logic         load_out, more_roots, root_last;
    tles_out_t    res_item;
    logic [123:0] sq_t, sq_rem, sq_res;
    logic         sq_ge;
    logic [95:0]  magc, mags;
    logic [64:0]  dc_step, ds_step;
    logic [31:0]  fld_c, fld_s;

    // signed 96-bit value from a magnitude and a sign
    function automatic logic [95:0] sgn96(input logic [95:0] m, input logic neg);
        return neg ? (~m + 96'd1) : m;
    endfunction

    // one restoring division step: {remainder, quotient bit}
    function automatic logic [64:0] div_step(input logic [63:0] r, input logic b,
                                             input logic [63:0] den);
        logic [64:0] r2;
        r2 = {r, b};
        if (r2 >= {1'b0, den})
            return {r2[63:0] - den, 1'b1};
        return {r2[63:0], 1'b0};
    endfunction

    // round to nearest, clamp to one and apply the sign
    function automatic logic [31:0] finish(input logic [32:0] q, input logic [63:0] r,
                                           input logic [63:0] den, input logic neg);
        logic [33:0] qq;
        logic [31:0] m;
        qq = {1'b0, q} + ((r >= den - r) ? 34'd1 : 34'd0);
        m  = (qq > {2'b0, ONE_Q30}) ? ONE_Q30 : qq[31:0];
        return neg ? (~m + 32'd1) : m;
    endfunction

    // square root step
    assign sq_t   = res_reg + bit_reg;
    assign sq_ge  = rem_reg >= sq_t;
    assign sq_rem = sq_ge ? rem_reg - sq_t : rem_reg;
    assign sq_res = sq_ge ? (res_reg >> 1) + bit_reg : (res_reg >> 1);

    // divider steps, cos and sin side by side
    assign dc_step = div_step(drc_reg, dlc_reg[32], ent_reg.s);
    assign ds_step = div_step(drs_reg, dls_reg[32], ent_reg.s);

    assign magc  = sgn96(ncos_reg, ncos_reg[95]);
    assign mags  = sgn96(nsin_reg, nsin_reg[95]);
    assign fld_c = finish(dqc_reg, drc_reg, ent_reg.s, negc_reg);
    assign fld_s = finish(dqs_reg, drs_reg, ent_reg.s, negs_reg);

    assign root_last  = second_reg || (ent_reg.d == 64'd0);
    assign more_roots = !root_last;
    assign load_out   = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign pop_ready  = (state_reg == ST_IDLE);

    // result item for the current position
    always_comb
    begin
        res_item = '0;
        unique case (ent_reg.kind)
            KIND_ROOTS:
            begin
                res_item.root_cos = cos_f_reg;
                res_item.root_sin = sin_f_reg;
                res_item.outcome  = OC_ROOT;
                res_item.last     = root_last;
            end
            KIND_IDENT:
            begin
                res_item.outcome = OC_SAMPLE;
                res_item.last    = (idx_reg == 2'd2);
                if (idx_reg == 2'd0)
                    res_item.root_cos = ONE_Q30;
                else if (idx_reg == 2'd1)
                    res_item.root_sin = ONE_Q30;
                else
                    res_item.root_cos = ~ONE_Q30 + 32'd1;
            end
            default:
            begin
                res_item.outcome = OC_NONE;
                res_item.last    = 1'b1;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (pop_valid)
                    state_next = (pop_data.kind == KIND_ROOTS) ? ST_SQRT : ST_EMIT;
            ST_SQRT:
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:   state_next = ST_NUM;
            ST_NUM:   state_next = ST_DLOAD;
            ST_DLOAD: state_next = ST_DIV;
            ST_DIV:
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_ROUND;
            ST_ROUND: state_next = ST_EMIT;
            ST_EMIT:
                if (load_out)
                begin
                    priority if (ent_reg.kind == KIND_ROOTS && more_roots)
                        state_next = ST_MUL;
                    else if (ent_reg.kind == KIND_IDENT && idx_reg != 2'd2)
                        state_next = ST_EMIT;
                    else
                        state_next = ST_IDLE;
                end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (pop_valid)
                begin
                    ent_reg    <= pop_data;
                    second_reg <= 1'b0;
                    idx_reg    <= 2'd0;
                    cnt_reg    <= '0;
                    rem_reg    <= {pop_data.d, 60'd0};
                    res_reg    <= '0;
                    bit_reg    <= 124'd1 << 122;
                end
            ST_SQRT:
            begin
                rem_reg <= sq_rem;
                res_reg <= sq_res;
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 1'b1;
                q_reg   <= sq_res[61:0];
            end
            ST_MUL:
            begin
                pa0_reg <= ent_reg.ma * q_reg[30:0];
                pa1_reg <= ent_reg.ma * q_reg[61:31];
                pb0_reg <= ent_reg.mb * q_reg[30:0];
                pb1_reg <= ent_reg.mb * q_reg[61:31];
            end
            ST_ADD:
            begin
                aq_reg <= {pa1_reg, 31'd0} + {31'd0, pa0_reg};
                bq_reg <= {pb1_reg, 31'd0} + {31'd0, pb0_reg};
            end
            ST_NUM:
            begin
                ncos_reg <= sgn96({2'd0, aq_reg}, ent_reg.sa != second_reg)
                          + sgn96({2'd0, ent_reg.bc, 30'd0}, ent_reg.sb == ent_reg.sc);
                nsin_reg <= sgn96({2'd0, ent_reg.ac, 30'd0}, ent_reg.sa == ent_reg.sc)
                          + sgn96({2'd0, bq_reg}, ent_reg.sb == second_reg);
            end
            ST_DLOAD:
            begin
                negc_reg <= ncos_reg[95];
                negs_reg <= nsin_reg[95];
                drc_reg  <= {1'b0, magc[95:33]};
                drs_reg  <= {1'b0, mags[95:33]};
                dlc_reg  <= magc[32:0];
                dls_reg  <= mags[32:0];
                dqc_reg  <= '0;
                dqs_reg  <= '0;
                cnt_reg  <= '0;
            end
            ST_DIV:
            begin
                drc_reg <= dc_step[64:1];
                drs_reg <= ds_step[64:1];
                dqc_reg <= {dqc_reg[31:0], dc_step[0]};
                dqs_reg <= {dqs_reg[31:0], ds_step[0]};
                dlc_reg <= {dlc_reg[31:0], 1'b0};
                dls_reg <= {dls_reg[31:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_ROUND:
            begin
                cos_f_reg <= fld_c;
                sin_f_reg <= fld_s;
            end
            ST_EMIT:
                if (load_out)
                begin
                    out_reg <= res_item;
                    if (ent_reg.kind == KIND_ROOTS)
                        second_reg <= 1'b1;
                    if (ent_reg.kind == KIND_IDENT)
                        idx_reg <= idx_reg + 1'b1;
                end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* sv/trig_linear_equation_solver_top.sv */
// Top level of the solver for a*sin(x) + b*cos(x) + c = 0.
// Depends on tles_pkg, tles_front, tles_fifo and tles_back.
`timescale 1ns / 1ps

// Coefficients a, b, c arrive as signed Q16.16 items; each item yields one to
// three result items (cos x, sin x in Q2.30, outcome, last). A two-stage front
// forms the exact squares and classifies, a four-entry queue holds classified
// items, and the back works them one at a time. In the back, an item with real
// roots (two, or a single tangent root) is loaded, runs 62 square-root steps,
// then per root passes multiply, add, numerator, divider load, 33 steps of the
// bit-serial dividers (cos and sin in parallel), rounding and emit. No-root and
// all-zero items go straight to emit. Square root and dividers set the rate.
// The front keeps accepting while the back works, until the queue fills.
module trig_linear_equation_solver_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tles_pkg::tles_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tles_pkg::tles_out_t out_data
);
    import tles_pkg::*;

    tles_entry_t fe_entry, q_entry;
    logic        fe_valid, fe_ready, q_valid, q_ready;

    tles_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .entry_valid (fe_valid),
        .entry_ready (fe_ready),
        .entry       (fe_entry)
    );

    tles_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_data  (fe_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_entry)
    );

    tles_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_data  (q_entry),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    // a no-root result closes its item and carries zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.outcome == OC_NONE |->
            out_data.last && out_data.root_cos == 32'sd0 && out_data.root_sin == 32'sd0)
        else $error("no-root item malformed");

    // root fields stay clamped to plus or minus one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            out_data.root_cos <= 32'sd1073741824 && out_data.root_cos >= -32'sd1073741824 &&
            out_data.root_sin <= 32'sd1073741824 && out_data.root_sin >= -32'sd1073741824)
        else $error("root field out of range");

    // outcome code 3 is never produced
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.outcome == OC_ROOT || out_data.outcome == OC_NONE ||
                      out_data.outcome == OC_SAMPLE)
        else $error("bad outcome code");
`endif

endmodule
